### design/assert_macros.svh
// Assertion macros used by the top-level RTL file of this project.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### design/mhfc_pkg.sv
// Package for the marker heading block: CORDIC constants and arctangent table.
// No dependencies.
package mhfc_pkg;
  localparam int unsigned ZFRAC      = 24;
  localparam int unsigned TABLE_LEN  = 24;
  localparam int unsigned BAND_FRAC  = 8;
  localparam int unsigned HEADING_W  = 17;
  localparam int unsigned BAND_W     = 15;
  localparam int unsigned ZW         = 35;
  localparam int unsigned PADDR_W    = 1;
  localparam logic [PADDR_W-1:0] REG_WRAP_BAND = 1'b0;

  typedef logic signed [ZW-1:0] z_t;

  function automatic z_t atan_entry(input int unsigned i);
    z_t r;
    unique case (i)
      0: r = 35'sd754974720;  1: r = 35'sd445687602;  2: r = 35'sd235489088;
      3: r = 35'sd119537938;  4: r = 35'sd60000934;   5: r = 35'sd30029717;
      6: r = 35'sd15018523;   7: r = 35'sd7509720;    8: r = 35'sd3754917;
      9: r = 35'sd1877466;    10: r = 35'sd938734;    11: r = 35'sd469367;
      12: r = 35'sd234684;    13: r = 35'sd117342;    14: r = 35'sd58671;
      15: r = 35'sd29335;     16: r = 35'sd14668;     17: r = 35'sd7334;
      18: r = 35'sd3667;      19: r = 35'sd1833;      20: r = 35'sd917;
      21: r = 35'sd458;       22: r = 35'sd229;       23: r = 35'sd115;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

### design/mhfc_cordic.sv
// Pipelined vectoring CORDIC: atan2(dy, dx) in degrees, one stage per micro-rotation.
// Depends on mhfc_pkg. Advances when adv_i is high.
module mhfc_cordic #(
  parameter int unsigned DW         = 21,
  parameter int unsigned FRAC       = 8,
  parameter int unsigned STEPS      = 16,
  parameter int unsigned OW         = 18
) (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  logic signed [DW-1:0] dy_i,
  input  logic signed [DW-1:0] dx_i,
  output logic signed [OW-1:0] ang_o
);
  // magnitude grows by up to ~1.65 after the quadrant fold
  localparam int unsigned XW = DW + 2;
  localparam int unsigned RSH = mhfc_pkg::ZFRAC - FRAC;

  mhfc_pkg::z_t         z_q [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic signed [OW-1:0] ang_q;

  // prescale by 2^24 only shifts; floor shifts of the scaled value equal
  // exact values here for i <= 24, so the unscaled datapath keeps extra
  // fraction bits instead: carry 24 fractional bits in x/y.
  localparam int unsigned FW = XW + mhfc_pkg::ZFRAC;
  logic signed [FW-1:0] xs_q [STEPS+1];
  logic signed [FW-1:0] ys_q [STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      logic signed [FW-1:0] xe, ye;
      xe = FW'(dx_i) <<< mhfc_pkg::ZFRAC;
      ye = FW'(dy_i) <<< mhfc_pkg::ZFRAC;
      zero_q[0] <= (dx_i == '0) && (dy_i == '0);
      if (dx_i < 0) begin
        if (dy_i >= 0) begin
          xs_q[0] <= ye; ys_q[0] <= -xe; z_q[0] <= mhfc_pkg::z_t'(90) <<< mhfc_pkg::ZFRAC;
        end else begin
          xs_q[0] <= -ye; ys_q[0] <= xe; z_q[0] <= -(mhfc_pkg::z_t'(90) <<< mhfc_pkg::ZFRAC);
        end
      end else begin
        xs_q[0] <= xe; ys_q[0] <= ye; z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        zero_q[i+1] <= zero_q[i];
        if (ys_q[i] >= 0) begin
          xs_q[i+1] <= xs_q[i] + (ys_q[i] >>> i);
          ys_q[i+1] <= ys_q[i] - (xs_q[i] >>> i);
          z_q[i+1]  <= z_q[i] + mhfc_pkg::atan_entry(i);
        end else begin
          xs_q[i+1] <= xs_q[i] - (ys_q[i] >>> i);
          ys_q[i+1] <= ys_q[i] + (xs_q[i] >>> i);
          z_q[i+1]  <= z_q[i] - mhfc_pkg::atan_entry(i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ang_q <= zero_q[STEPS] ? '0 :
               OW'((z_q[STEPS] + (mhfc_pkg::z_t'(1) <<< (RSH - 1))) >>> RSH);
    end
  end

  assign ang_o = ang_q;
endmodule

### design/marker_heading_from_corners.sv
// Marker heading from four corners: top level with APB config and pipelined datapath.
// Depends on mhfc_pkg, mhfc_cordic and assert_macros.svh.
// One marker is accepted per cycle while the output does not stall; the result passes through
// the four parallel CORDIC pipelines (input, one micro-rotation per stage, rounding) and then
// the fold, correction and mean/output stages. The whole pipeline holds when the output stalls.
`include "assert_macros.svh"
module marker_heading_from_corners #(
  parameter int unsigned COORD_WIDTH     = 20,
  parameter int unsigned ANGLE_FRAC_BITS = 8,
  parameter int unsigned CORDIC_STEPS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mhfc_pkg::PADDR_W+1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic signed [COORD_WIDTH-1:0] corner0_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner0_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner1_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner2_y_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_x_i,
  input  logic signed [COORD_WIDTH-1:0] corner3_y_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [ANGLE_FRAC_BITS+8:0]    heading_o,
  output logic                          wrap_corrected_o
);
  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned AW   = ANGLE_FRAC_BITS + 11;   // signed, holds +-720
  localparam int unsigned SW   = AW + 3;
  localparam int unsigned HW   = ANGLE_FRAC_BITS + 9;
  localparam int unsigned LAT  = CORDIC_STEPS + 2;
  localparam logic signed [AW-1:0] FULL = AW'(360) <<< ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] ONE  = AW'(1) <<< ANGLE_FRAC_BITS;

  logic [mhfc_pkg::BAND_W-1:0] band_q;
  logic adv;
  logic [LAT-1:0] vld_q;
  logic fv_q, cv_q, ov_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q <= mhfc_pkg::BAND_W'(2560);
    end else if (psel && penable && pwrite &&
                 paddr[mhfc_pkg::PADDR_W+1:2] == mhfc_pkg::REG_WRAP_BAND &&
                 paddr[1:0] == 2'b00) begin
      band_q <= pwdata[mhfc_pkg::BAND_W-1:0];
    end
  end
  assign prdata = (paddr[mhfc_pkg::PADDR_W+1:2] == mhfc_pkg::REG_WRAP_BAND)
                  ? 32'(band_q) : '0;

  assign adv     = !(ov_q && stall_i);
  assign stall_o = !adv;

  logic signed [COORD_WIDTH-1:0] cx [4], cy [4];
  assign cx[0] = corner0_x_i; assign cy[0] = corner0_y_i;
  assign cx[1] = corner1_x_i; assign cy[1] = corner1_y_i;
  assign cx[2] = corner2_x_i; assign cy[2] = corner2_y_i;
  assign cx[3] = corner3_x_i; assign cy[3] = corner3_y_i;

  logic signed [AW-1:0] t [4];
  for (genvar k = 0; k < 4; k++) begin : g_edge
    localparam int P = (k + 3) % 4;
    mhfc_cordic #(.DW(DW), .FRAC(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .OW(AW)) u_cordic (
      .clk_i (clk_i),
      .adv_i (adv),
      .dy_i  (DW'(cy[P]) - DW'(cy[k])),
      .dx_i  (DW'(cx[k]) - DW'(cx[P])),
      .ang_o (t[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[LAT-2:0], valid_i};
  end

  // fold stage: rotation, wrap, classify
  logic signed [AW-1:0] band;
  assign band = (ANGLE_FRAC_BITS >= mhfc_pkg::BAND_FRAC)
    ? AW'(band_q) <<< (ANGLE_FRAC_BITS - mhfc_pkg::BAND_FRAC)
    : AW'(band_q >> (mhfc_pkg::BAND_FRAC - ANGLE_FRAC_BITS));

  logic signed [AW-1:0] a_q [4];
  logic [3:0] lo_q, hi_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [AW-1:0] a;
        unique case (k)
          0: a = -t[k];
          1: a = AW'(90) * ONE - t[k];
          2: a = AW'(180) * ONE - t[k];
          default: a = -AW'(90) * ONE - t[k];
        endcase
        if (a < 0) a = a + FULL;
        if (a < 0) a = a + FULL;
        if (a >= FULL) a = a - FULL;
        a_q[k]  <= a;
        lo_q[k] <= a < band;
        hi_q[k] <= !(a < band) && (a > FULL - band);
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fv_q <= 1'b0;
    else if (adv) fv_q <= vld_q[LAT-1];
  end

  // correction stage: move the minority side of the wrap band by a full turn (the high side on a tie)
  logic [2:0] nlo, nhi;
  logic corr;
  logic signed [SW-1:0] c_d [4];
  always_comb begin
    nlo = 3'($countones(lo_q));
    nhi = 3'($countones(hi_q));
    corr = (nlo + nhi == 3'd4) && nlo != 0 && nhi != 0;
    for (int k = 0; k < 4; k++) begin
      logic signed [SW-1:0] a;
      a = SW'(a_q[k]);
      if (corr && nlo >= nhi && hi_q[k]) a = a - SW'(FULL);
      if (corr && nlo < nhi && lo_q[k]) a = a + SW'(FULL);
      c_d[k] = a;
    end
  end

  logic signed [SW-1:0] c_q [4];
  logic cr_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) c_q[k] <= c_d[k];
      cr_q <= corr;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cv_q <= 1'b0;
    else if (adv) cv_q <= fv_q;
  end

  // mean stage
  logic signed [SW-1:0] sum, avg;
  always_comb begin
    sum = (c_q[0] + c_q[1]) + (c_q[2] + c_q[3]);
    avg = (sum + SW'(2)) >>> 2;
    if (cr_q && avg > SW'(FULL)) avg = avg - SW'(FULL);
    if (cr_q && avg < 0) avg = avg + SW'(FULL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (adv) ov_q <= cv_q;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      heading_o        <= HW'(avg);
      wrap_corrected_o <= cr_q;
    end
  end
  assign valid_o = ov_q;

  `ASSERT_NEXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(heading_o))
  `ASSERT_IMPLIES(a_stall, clk_i, rst_ni, stall_o, valid_o && stall_i)
  `ASSERT_IMPLIES(a_range, clk_i, rst_ni, valid_o, heading_o <= HW'(FULL))
endmodule

### bench/tb.sv
// Testbench for marker_heading_from_corners: random and directed corner sets, APB band writes.
// Depends on mhfc_pkg and the block RTL; holds its own heading predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 20;
  localparam int AFB = 8;
  localparam int STEPS = 16;
  localparam longint FULL_DEG = longint'(360) << AFB;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [mhfc_pkg::PADDR_W+1:0] BAND_ADDR = {mhfc_pkg::REG_WRAP_BAND, 2'b00};

  typedef logic signed [CW-1:0] coord_t;
  typedef struct packed {
    coord_t x0, y0, x1, y1, x2, y2, x3, y3;
  } marker_t;
  typedef struct packed {
    logic [mhfc_pkg::HEADING_W-1:0] heading;
    logic                           wrapped;
  } heading_t;

  // atan(2^-i) in degrees, 24 fractional bits
  localparam longint ARCTAN_DEG [0:23] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335, 14668, 7334,
    3667, 1833, 917, 458, 229, 115};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [mhfc_pkg::PADDR_W+1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic valid_i = 1'b0;
  logic stall_o;
  marker_t mk = '0;
  logic valid_o;
  logic stall_i = 1'b0;
  logic [mhfc_pkg::HEADING_W-1:0] heading_o;
  logic wrap_corrected_o;

  logic [mhfc_pkg::BAND_W-1:0] band_reg;
  heading_t heading_q[$];
  int errors = 0;
  int cycles = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;

  always #5 clk_i = ~clk_i;

  marker_heading_from_corners u_top (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .valid_i, .stall_o,
    .corner0_x_i(mk.x0), .corner0_y_i(mk.y0), .corner1_x_i(mk.x1), .corner1_y_i(mk.y1),
    .corner2_x_i(mk.x2), .corner2_y_i(mk.y2), .corner3_x_i(mk.x3), .corner3_y_i(mk.y3),
    .valid_o, .stall_i, .heading_o, .wrap_corrected_o
  );

  // atan2(dy, dx) in degrees, AFB fractional bits, vectoring CORDIC
  function automatic longint edge_angle(longint dy, longint dx);
    longint x, y, z, nx, ny;
    if (dx == 0 && dy == 0) return 0;
    x = dx <<< 24;
    y = dy <<< 24;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y; ny = -x; z = longint'(90) <<< 24;
      end else begin
        nx = -y; ny = x; z = -(longint'(90) <<< 24);
      end
      x = nx; y = ny;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += ARCTAN_DEG[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= ARCTAN_DEG[i];
      end
      x = nx; y = ny;
    end
    return (z + (longint'(1) <<< (24 - AFB - 1))) >>> (24 - AFB);
  endfunction

  function automatic heading_t predict_heading(marker_t m);
    longint cx[4], cy[4], ang[4], offs[4];
    longint band, sum, avg, a;
    int nlow, nhigh, p;
    bit corr;
    heading_t r;
    cx = '{m.x0, m.x1, m.x2, m.x3};
    cy = '{m.y0, m.y1, m.y2, m.y3};
    offs = '{0, 90, 180, -90};
    band = band_reg;
    nlow = 0; nhigh = 0; sum = 0;
    for (int k = 0; k < 4; k++) begin
      p = (k + 3) % 4;
      a = (offs[k] <<< AFB) - edge_angle(cy[p] - cy[k], cx[k] - cx[p]);
      while (a < 0) a += FULL_DEG;
      while (a >= FULL_DEG) a -= FULL_DEG;
      ang[k] = a;
      if (a < band) nlow++;
      else if (a > FULL_DEG - band) nhigh++;
    end
    corr = (nlow + nhigh == 4) && nlow != 0 && nhigh != 0;
    for (int k = 0; k < 4; k++) begin
      a = ang[k];
      if (corr && nlow >= nhigh && a > FULL_DEG - band) a -= FULL_DEG;
      if (corr && nlow < nhigh && a < band) a += FULL_DEG;
      sum += a;
    end
    avg = (sum + 2) >>> 2;
    if (corr && avg > FULL_DEG) avg -= FULL_DEG;
    if (corr && avg < 0) avg += FULL_DEG;
    r.heading = avg[mhfc_pkg::HEADING_W-1:0];
    r.wrapped = corr;
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // output back-pressure
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      stall_i <= 1'b1;
    end else begin
      stall_left <= idle_len();
      stall_i <= 1'b0;
    end
  end

  // result checker; sampled mid-cycle, so values hold at the next rising edge
  always @(negedge clk_i) begin
    heading_t exp_h;
    if (rst_ni && valid_o && !stall_i) begin
      if (heading_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result heading=%0d", heading_o);
      end else begin
        exp_h = heading_q.pop_front();
        if (exp_h.heading !== heading_o || exp_h.wrapped !== wrap_corrected_o) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: heading exp %0d got %0d, wrap exp %0d got %0d",
                     exp_h.heading, heading_o, exp_h.wrapped, wrap_corrected_o);
        end
      end
    end
  end

  task automatic send_marker(marker_t m);
    int gap;
    bit blocked;
    gap = gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i <= 1'b1;
    mk <= m;
    do begin
      @(negedge clk_i);
      blocked = stall_o;
      @(posedge clk_i);
    end while (blocked);
    heading_q = {heading_q, predict_heading(m)};
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (STEPS + 10) @(posedge clk_i);
  endtask

  task automatic write_band(logic [mhfc_pkg::BAND_W-1:0] v);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= BAND_ADDR;
    pwdata <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    band_reg = v;
  endtask

  // square marker with edge vector (u, w) from corner 3 to corner 0
  function automatic marker_t square(int bx, int by, int u, int w, int jit);
    marker_t m;
    m.x3 = coord_t'(bx);         m.y3 = coord_t'(by);
    m.x0 = coord_t'(bx + u);     m.y0 = coord_t'(by + w);
    m.x1 = coord_t'(bx + u + w); m.y1 = coord_t'(by + w - u);
    m.x2 = coord_t'(bx + w);     m.y2 = coord_t'(by - u);
    if (jit > 0) begin
      m.x0 = coord_t'(m.x0 + $urandom_range(0, 2 * jit) - jit);
      m.y0 = coord_t'(m.y0 + $urandom_range(0, 2 * jit) - jit);
      m.x1 = coord_t'(m.x1 + $urandom_range(0, 2 * jit) - jit);
      m.y2 = coord_t'(m.y2 + $urandom_range(0, 2 * jit) - jit);
    end
    return m;
  endfunction

  function automatic marker_t random_marker();
    marker_t m;
    int r, u, w;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      m = marker_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    end else if (r < 32) begin
      m = '0;
      m.x0 = coord_t'($urandom); m.y0 = coord_t'($urandom);
      m.x1 = m.x0; m.y1 = m.y0;
      m.x2 = coord_t'($urandom); m.y2 = m.y0;
      m.x3 = m.x2; m.y3 = m.y2;
    end else begin
      if ($urandom_range(0, 1)) begin
        u = $urandom_range(20, 60000);
        w = $urandom_range(0, u / 5) - u / 10;
      end else begin
        u = $urandom_range(0, 120000) - 60000;
        w = $urandom_range(0, 120000) - 60000;
      end
      m = square($urandom_range(0, 400000) - 200000, $urandom_range(0, 400000) - 200000,
                 u, w, $urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
    end
    return m;
  endfunction

  task automatic test_directed();
    marker_t m;
    send_marker('0);                                  // all corners equal
    m = '0; m.x0 = coord_t'(-524288); m.y0 = coord_t'(-524288);
    m.x1 = coord_t'(524287); m.y1 = coord_t'(524287);
    m.x2 = coord_t'(-524288); m.y2 = coord_t'(524287);
    m.x3 = coord_t'(524287); m.y3 = coord_t'(-524288);
    send_marker(m);
    m = '1; send_marker(m);
    send_marker(square(0, 0, 1000, 0, 0));            // heading exactly zero
    send_marker(square(0, 0, -1000, 0, 0));           // edges on negative x axis
    send_marker(square(100, -50, 1000, 5, 0));
    send_marker(square(100, -50, 1000, -5, 0));
    send_marker(square(0, 0, 1000, 20, 3));
    send_marker(square(7, 7, 0, 1000, 0));
    send_marker(square(7, 7, 0, -1000, 0));
    send_marker(square(-300, 40, 707, 707, 0));
    send_marker(square(0, 0, 16, 1, 0));
    send_marker(square(0, 0, 262143, 3, 0));
    m = square(0, 0, 1000, 0, 0); m.x1 = m.x0; m.y1 = m.y0;   // one degenerate edge
    send_marker(m);
    m = square(0, 0, 1000, 0, 0);                              // edges 0 and 2 just above zero, then just below
    m.y0 = coord_t'(m.y0 + 8); m.y2 = coord_t'(m.y2 - 8);
    send_marker(m);
    m = square(0, 0, 1000, 0, 0);
    m.y0 = coord_t'(m.y0 - 8); m.y2 = coord_t'(m.y2 + 8);
    send_marker(m);
    m = '0; m.x0 = coord_t'(1); m.x1 = coord_t'(-524288); m.y2 = coord_t'(524287);
    m.x3 = coord_t'(-1); m.y3 = coord_t'(-524288);
    send_marker(m);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 150 == 0) begin
        gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      send_marker(random_marker());
    end
  endtask

  task automatic test_band_settings();
    logic [mhfc_pkg::BAND_W-1:0] bands [6];
    bands = '{0, 1, 23040, 32767, 256, 2560};
    foreach (bands[i]) begin
      write_band(bands[i]);
      test_random(120);
      test_directed();
    end
    write_band(mhfc_pkg::BAND_W'($urandom_range(0, 23040)));
    test_random(150);
  endtask

  initial begin
    band_reg = 2560;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_directed();
    test_band_settings();
    write_band(2560);
    test_random(750);
    drain();
    repeat (30) @(posedge clk_i);
    if (errors == 0 && heading_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule

### files.f
+incdir+design
design/mhfc_pkg.sv
design/mhfc_cordic.sv
design/marker_heading_from_corners.sv
bench/tb.sv
